@@ design/rau_pkg.sv @@
package rau_pkg;

  localparam int MAG_W = 65;

  typedef enum logic [2:0] {
    CMD_NORM = 3'd0,
    CMD_ADD  = 3'd1,
    CMD_SUB  = 3'd2,
    CMD_MUL  = 3'd3,
    CMD_DIV  = 3'd4
  } cmd_t;

  typedef enum logic [1:0] {
    ERR_OK   = 2'd0,
    ERR_ZDEN = 2'd1,
    ERR_OVF  = 2'd2
  } err_t;

  // One classified item: raw sign-magnitude fraction, ready for reduction
  typedef struct packed {
    logic             zero_den;
    logic             neg;
    logic [MAG_W-1:0] nm;
    logic [MAG_W-1:0] dm;
  } job_t;

  typedef enum logic [2:0] {
    BS_IDLE = 3'd0,
    BS_GCD  = 3'd1,
    BS_DIVN = 3'd2,
    BS_DIVD = 3'd3,
    BS_OUT  = 3'd4
  } bstate_t;

  // Front-end sequencer states
  typedef enum logic [2:0] {
    FS_IDLE = 3'd0,
    FS_M1   = 3'd1,
    FS_M2   = 3'd2,
    FS_M3   = 3'd3,
    FS_SUM  = 3'd4,
    FS_PUSH = 3'd5
  } fstate_t;

endpackage

@@ design/rau_front.sv @@
// Front end: takes an item, forms raw numerator and denominator with one
// shared multiplier, then pushes the job to the queue.
module rau_front #(
  parameter int WIDTH = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [2:0]          cmd,
  input  logic [31:0]         a_num,
  input  logic [31:0]         a_den,
  input  logic [31:0]         b_num,
  input  logic [31:0]         b_den,
  output logic                job_valid,
  input  logic                job_ready,
  output rau_pkg::job_t       job
);

  localparam int MW = rau_pkg::MAG_W;
  localparam int OW = WIDTH + 1;

  rau_pkg::fstate_t state_r, state_nxt;
  logic [2:0]    cmd_r;
  logic          an_s_r, ad_s_r, bn_s_r, bd_s_r;
  logic [OW-1:0] an_r, ad_r, bn_r, bd_r;
  logic [MW-1:0] p1_r, p2_r, p3_r;
  logic          p1_s_r, p2_s_r, p3_s_r;
  rau_pkg::job_t job_r, job_nxt;

  logic [OW-1:0] mx, my;
  logic          msx, msy;
  logic [MW-1:0] prod;
  logic          psgn;

  // signed field to sign and magnitude
  function automatic logic [OW:0] to_sm(input logic [31:0] raw);
    logic [WIDTH-1:0] v;
    logic [OW-1:0]    m;
    begin
      v = raw[WIDTH-1:0];
      if (v[WIDTH-1]) m = OW'(({1'b1, {WIDTH{1'b0}}}) - {1'b0, v});
      else m = {1'b0, v};
      to_sm = {v[WIDTH-1], m};
    end
  endfunction

  logic [OW:0] sm_an, sm_ad, sm_bn, sm_bd;
  assign sm_an = to_sm(a_num);
  assign sm_ad = to_sm(a_den);
  assign sm_bn = to_sm(b_num);
  assign sm_bd = to_sm(b_den);

  // operand select for the shared multiplier
  always_comb begin
    mx = an_r; my = bd_r; msx = an_s_r; msy = bd_s_r;
    case (state_r)
      rau_pkg::FS_M1: begin
        mx = an_r; msx = an_s_r;
        if (cmd_r == rau_pkg::CMD_MUL) begin
          my = bn_r; msy = bn_s_r;
        end else begin
          my = bd_r; msy = bd_s_r;
        end
      end
      rau_pkg::FS_M2: begin
        mx = ad_r; msx = ad_s_r;
        if (cmd_r == rau_pkg::CMD_DIV) begin
          my = bn_r; msy = bn_s_r;
        end else begin
          my = bd_r; msy = bd_s_r;
        end
      end
      default: begin
        mx = bn_r; msx = bn_s_r; my = ad_r; msy = ad_s_r;
      end
    endcase
  end

  assign prod = MW'(mx * my);
  assign psgn = (msx ^ msy) && (prod != '0);

  // sum of the two cross products
  logic [MW-1:0] s_mag;
  logic          s_neg, b_neg;
  always_comb begin
    b_neg = p3_s_r;
    if (cmd_r == rau_pkg::CMD_SUB) b_neg = ~p3_s_r && (p3_r != '0);
    if (p1_s_r == b_neg) begin
      s_mag = p1_r + p3_r; s_neg = p1_s_r;
    end else if (p1_r >= p3_r) begin
      s_mag = p1_r - p3_r; s_neg = p1_s_r;
    end else begin
      s_mag = p3_r - p1_r; s_neg = b_neg;
    end
    if (s_mag == '0) s_neg = 1'b0;
  end

  logic is_norm;
  assign is_norm = !(cmd_r == rau_pkg::CMD_ADD || cmd_r == rau_pkg::CMD_SUB ||
                     cmd_r == rau_pkg::CMD_MUL || cmd_r == rau_pkg::CMD_DIV);

  // sequencer
  always_comb begin
    state_nxt = state_r;
    job_nxt   = job_r;
    in_ready  = (state_r == rau_pkg::FS_IDLE);
    job_valid = (state_r == rau_pkg::FS_PUSH);
    case (state_r)
      rau_pkg::FS_IDLE: if (in_valid) state_nxt = rau_pkg::FS_M1;
      rau_pkg::FS_M1: begin
        if (is_norm) begin
          job_nxt.zero_den = (ad_r == '0);
          job_nxt.neg      = an_s_r ^ ad_s_r;
          job_nxt.nm       = MW'(an_r);
          job_nxt.dm       = MW'(ad_r);
          state_nxt = rau_pkg::FS_PUSH;
        end else begin
          state_nxt = rau_pkg::FS_M2;
        end
      end
      rau_pkg::FS_M2: begin
        if (cmd_r == rau_pkg::CMD_MUL || cmd_r == rau_pkg::CMD_DIV) begin
          job_nxt.zero_den = (ad_r == '0) || (bd_r == '0) || (prod == '0);
          job_nxt.neg      = p1_s_r ^ psgn;
          job_nxt.nm       = p1_r;
          job_nxt.dm       = prod;
          state_nxt = rau_pkg::FS_PUSH;
        end else begin
          state_nxt = rau_pkg::FS_M3;
        end
      end
      rau_pkg::FS_M3: state_nxt = rau_pkg::FS_SUM;
      rau_pkg::FS_SUM: begin
        job_nxt.zero_den = (ad_r == '0) || (bd_r == '0) || (p2_r == '0);
        job_nxt.neg      = s_neg ^ p2_s_r;
        job_nxt.nm       = s_mag;
        job_nxt.dm       = p2_r;
        state_nxt = rau_pkg::FS_PUSH;
      end
      rau_pkg::FS_PUSH: if (job_ready) state_nxt = rau_pkg::FS_IDLE;
      default: state_nxt = rau_pkg::FS_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= rau_pkg::FS_IDLE;
    else state_r <= state_nxt;
  end

  // operand and product registers
  always_ff @(posedge clk) begin
    job_r <= job_nxt;
    if (state_r == rau_pkg::FS_IDLE && in_valid) begin
      cmd_r <= cmd;
      {an_s_r, an_r} <= sm_an;
      {ad_s_r, ad_r} <= sm_ad;
      {bn_s_r, bn_r} <= sm_bn;
      {bd_s_r, bd_r} <= sm_bd;
    end
    case (state_r)
      rau_pkg::FS_M1: begin p1_r <= prod; p1_s_r <= psgn; end
      rau_pkg::FS_M2: begin p2_r <= prod; p2_s_r <= psgn; end
      rau_pkg::FS_M3: begin p3_r <= prod; p3_s_r <= psgn; end
      default: ;
    endcase
  end

  assign job = job_r;

endmodule

@@ design/rau_queue.sv @@
// Two-entry queue between front and back ends.
module rau_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          wr_valid,
  output logic          wr_ready,
  input  rau_pkg::job_t wr_data,
  output logic          rd_valid,
  input  logic          rd_ready,
  output rau_pkg::job_t rd_data
);

  rau_pkg::job_t mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  logic       wr_en, rd_en;

  assign wr_ready = (cnt_r != 2'd2);
  assign rd_valid = (cnt_r != 2'd0);
  assign wr_en    = wr_valid && wr_ready;
  assign rd_en    = rd_valid && rd_ready;
  assign rd_data  = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (wr_en) mem_r[wp_r] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0; rp_r <= 1'b0; cnt_r <= 2'd0;
    end else begin
      if (wr_en) wp_r <= ~wp_r;
      if (rd_en) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, wr_en} - {1'b0, rd_en};
    end
  end

endmodule

@@ design/rau_back.sv @@
// Back end: Euclidean GCD by a shared restoring remainder unit (one bit per
// cycle), then exact division of numerator and denominator, range check.
module rau_back #(
  parameter int WIDTH = 32
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          job_valid,
  output logic          job_ready,
  input  rau_pkg::job_t job,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [31:0]   res_num,
  output logic [30:0]   res_den,
  output logic [1:0]    error
);

  localparam int MW = rau_pkg::MAG_W;
  localparam int CW = $clog2(MW + 1);

  rau_pkg::bstate_t state_r, state_nxt;
  logic [MW-1:0] nm_r, dm_r, y_r;
  logic [MW-1:0] q_r, rem_r, dvd_r, g_r, qn_r;
  logic [CW-1:0] bit_r;
  logic          neg_r, zd_r;
  logic [31:0]   num_o_r;
  logic [30:0]   den_o_r;
  logic [1:0]    err_o_r;
  logic          start;

  // one restoring division step
  logic [MW:0]   trial;
  logic [MW-1:0] rem_sh;
  assign rem_sh = {rem_r[MW-2:0], dvd_r[MW-1]};
  assign trial  = {1'b0, rem_sh} - {1'b0, (state_r == rau_pkg::BS_GCD) ? y_r : g_r};
  logic          last_bit;
  assign last_bit = (bit_r == CW'(MW - 1));

  logic [MW-1:0] rem_new;
  assign rem_new = trial[MW] ? rem_sh : trial[MW-1:0];

  localparam logic [MW-1:0] LIM = MW'(1) << (WIDTH - 1);

  logic ovf;
  logic [MW-1:0] nres;
  assign ovf  = (q_r > LIM - MW'(1)) || (qn_r > (neg_r ? LIM : LIM - MW'(1)));
  assign nres = neg_r ? (MW'(0) - qn_r) : qn_r;

  assign job_ready = (state_r == rau_pkg::BS_IDLE);
  assign start     = job_valid && job_ready;
  assign out_valid = (state_r == rau_pkg::BS_OUT);
  assign res_num   = num_o_r;
  assign res_den   = den_o_r;
  assign error     = err_o_r;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      rau_pkg::BS_IDLE: begin
        if (start) begin
          if (job.zero_den || job.nm == '0) state_nxt = rau_pkg::BS_OUT;
          else state_nxt = rau_pkg::BS_GCD;
        end
      end
      rau_pkg::BS_GCD: if (last_bit && rem_new == '0) state_nxt = rau_pkg::BS_DIVN;
      rau_pkg::BS_DIVN: if (last_bit) state_nxt = rau_pkg::BS_DIVD;
      rau_pkg::BS_DIVD: if (last_bit) state_nxt = rau_pkg::BS_OUT;
      rau_pkg::BS_OUT: if (out_ready) state_nxt = rau_pkg::BS_IDLE;
      default: state_nxt = rau_pkg::BS_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= rau_pkg::BS_IDLE;
    else state_r <= state_nxt;
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state_r)
      rau_pkg::BS_IDLE: begin
        nm_r <= job.nm; dm_r <= job.dm; neg_r <= job.neg; zd_r <= job.zero_den;
        y_r <= job.dm;
        dvd_r <= job.nm; rem_r <= '0; bit_r <= '0; q_r <= '0;
        err_o_r <= job.zero_den ? rau_pkg::ERR_ZDEN : rau_pkg::ERR_OK;
        num_o_r <= '0;
        den_o_r <= (job.zero_den || job.nm != '0) ? 31'd0 : 31'd1;
      end
      rau_pkg::BS_GCD: begin
        if (last_bit) begin
          bit_r <= '0;
          rem_r <= '0;
          if (rem_new == '0) begin
            g_r <= y_r; dvd_r <= nm_r;
          end else begin
            y_r <= rem_new; dvd_r <= y_r;
          end
        end else begin
          dvd_r <= {dvd_r[MW-2:0], 1'b0};
          rem_r <= rem_new;
          bit_r <= bit_r + CW'(1);
        end
      end
      rau_pkg::BS_DIVN, rau_pkg::BS_DIVD: begin
        q_r <= {q_r[MW-2:0], ~trial[MW]};
        if (last_bit) begin
          bit_r <= '0; rem_r <= '0; dvd_r <= dm_r;
          if (state_r == rau_pkg::BS_DIVN) qn_r <= {q_r[MW-2:0], ~trial[MW]};
        end else begin
          dvd_r <= {dvd_r[MW-2:0], 1'b0};
          rem_r <= rem_new;
          bit_r <= bit_r + CW'(1);
        end
      end
      rau_pkg::BS_OUT: ;
      default: ;
    endcase
    // results once both quotients are in
    if (state_r == rau_pkg::BS_OUT && !zd_r && nm_r != '0 && bit_r == '0) begin
      bit_r <= CW'(1);
      if (ovf) begin
        err_o_r <= rau_pkg::ERR_OVF; num_o_r <= '0; den_o_r <= '0;
      end else begin
        num_o_r <= 32'(signed'(nres[WIDTH-1:0]));
        den_o_r <= 31'(q_r);
      end
    end
  end

endmodule

@@ design/rational_arithmetic_unit.sv @@
// Rational arithmetic unit: takes a command and two fractions and returns the
// result reduced to lowest terms with a positive denominator. In the front
// end one shared multiplier forms the cross products; the back end then runs
// the Euclidean remainder steps and the two exact divisions, all on one
// bit-serial remainder unit. Zero denominators and zero numerators skip the
// back-end loop. A two-entry queue lets the front end take the next item
// meanwhile. Results are valid in the cycle after entering the output state
// and held until taken.
module rational_arithmetic_unit #(
  parameter int WIDTH = 32
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // [2:0] cmd, [34:3] a_num, [66:35] a_den, [98:67] b_num, [130:99] b_den
  input  logic [135:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // [31:0] res_num, [62:32] res_den, [64:63] error
  output logic [71:0]  out_tdata
);

  logic          fj_valid, fj_ready, bj_valid, bj_ready;
  rau_pkg::job_t fj, bj;
  logic [31:0]   res_num;
  logic [30:0]   res_den;
  logic [1:0]    error;
  logic          bv;

  rau_front #(.WIDTH(WIDTH)) u_front (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_tvalid), .in_ready(in_tready),
    .cmd(in_tdata[2:0]), .a_num(in_tdata[34:3]), .a_den(in_tdata[66:35]),
    .b_num(in_tdata[98:67]), .b_den(in_tdata[130:99]),
    .job_valid(fj_valid), .job_ready(fj_ready), .job(fj)
  );

  rau_queue u_queue (
    .clk(clk), .rst_n(rst_n),
    .wr_valid(fj_valid), .wr_ready(fj_ready), .wr_data(fj),
    .rd_valid(bj_valid), .rd_ready(bj_ready), .rd_data(bj)
  );

  rau_back #(.WIDTH(WIDTH)) u_back (
    .clk(clk), .rst_n(rst_n),
    .job_valid(bj_valid), .job_ready(bj_ready), .job(bj),
    .out_valid(bv), .out_ready(out_tready && out_tvalid),
    .res_num(res_num), .res_den(res_den), .error(error)
  );

  // hold valid back through a register so the final result write has landed
  logic bv_d_r;
  always_ff @(posedge clk) begin
    if (!rst_n) bv_d_r <= 1'b0;
    else if (out_tvalid && out_tready) bv_d_r <= 1'b0;
    else bv_d_r <= bv;
  end

  assign out_tvalid = bv && bv_d_r;
  assign out_tdata  = {7'd0, error, res_den, res_num};

`ifndef SYNTHESIS
  a_err_zero_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[64:63] != 2'd0 |-> out_tdata[62:0] == '0)
    else $error("error result with non-zero fields");
  a_den_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[64:63] == 2'd0 |-> out_tdata[62:32] != '0)
    else $error("ok result with zero denominator");
  a_zero_num_den1: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[64:63] == 2'd0 && out_tdata[31:0] == '0
    |-> out_tdata[62:32] == 31'd1)
    else $error("zero numerator without unit denominator");
`endif

endmodule
